### hdl/lwct_pkg.sv
// Package for the LRU write-back cache tag store.
// Holds shared constants, the controller/datapath command and status structs.
// No dependencies.
package lwct_pkg;

    localparam int MAX_SETS = 256;
    localparam int MAX_WAYS = 8;
    localparam int ADDR_W   = 32;
    localparam int CFG_W    = 4;
    localparam int RANK_W   = 3;
    localparam logic [RANK_W-1:0] RANK_TOP = 3'd7;
    localparam logic [CFG_W-1:0] OFFSET_RESET = 4'd3;
    localparam logic [CFG_W-1:0] INDEX_RESET  = 4'd4;
    localparam logic [CFG_W-1:0] WAYS_RESET   = 4'd8;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_OFFSET = 2'd0;
    localparam logic [1:0] REG_INDEX  = 2'd1;
    localparam logic [1:0] REG_WAYS   = 2'd2;

    typedef struct packed {
        logic clear;      // clear one set of state
        logic lookup;     // capture item, read the set
        logic update;     // write back the set and register the result
    } cmd_t;

    typedef struct packed {
        logic clear_done;
    } status_t;

endpackage

### hdl/lwct_ctrl.sv
// Controller for the LRU write-back cache tag store.
// Sequences the reset clearing pass and the lookup-then-update of each access.
// Depends on lwct_pkg.
module lwct_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output lwct_pkg::cmd_t    cmd,
    input  lwct_pkg::status_t status
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_UPD   = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    // Accept only when the result register is free (or freeing).
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.lookup = 1'b1;
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.update   = 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_upd_after_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.lookup |=> cmd.update) else $error("update did not follow lookup");
    a_result_on_update: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> m_valid) else $error("no result after update");
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> !s_ready) else $error("accept during clearing pass");

endmodule

### hdl/lwct_dp.sv
// Datapath for the LRU write-back cache tag store: set memory, tag compare,
// victim choice and recency update. Depends on lwct_pkg.
module lwct_dp #(
    parameter int SETS = lwct_pkg::MAX_SETS,
    parameter int WAYS = lwct_pkg::MAX_WAYS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lwct_pkg::cmd_t               cmd,
    output lwct_pkg::status_t            status,
    input  logic [lwct_pkg::CFG_W-1:0]   offset_bits,
    input  logic [lwct_pkg::CFG_W-1:0]   index_bits,
    input  logic [lwct_pkg::CFG_W-1:0]   ways_in_use,
    input  logic                         s_mode,
    input  logic [lwct_pkg::ADDR_W-1:0]  s_address,
    output logic                         m_hit,
    output logic                         m_write_back,
    output logic [2:0]                   m_way_used
);

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int MAX_IB = $clog2(SETS + 1) - 1;
    localparam int RW     = lwct_pkg::RANK_W;
    localparam int AW     = lwct_pkg::ADDR_W;
    // One memory row holds a whole set: per way valid, dirty, rank, tag.
    localparam int LINE_W = 2 + RW + AW;
    localparam int ROW_W  = LINE_W * WAYS;

    typedef struct packed {
        logic          valid;
        logic          dirty;
        logic [RW-1:0] rank;
        logic [AW-1:0] tag;
    } line_t;

    logic [ROW_W-1:0] mem [SETS];
    logic [ROW_W-1:0] rd_row_reg;
    logic [SET_W-1:0] set_reg, clr_ptr_reg;
    logic [AW-1:0]    tag_reg;
    logic             mode_reg;
    logic [WAY_W:0]   nways_reg;
    logic             hit_reg, wb_reg;
    logic [2:0]       way_reg;

    // Address split
    logic [3:0]       ib;
    logic [4:0]       sh_tot;
    logic [AW-1:0]    shifted, set_mask, set_full;
    logic [WAY_W:0]   nways;

    always_comb begin
        ib       = (index_bits > 4'(MAX_IB)) ? 4'(MAX_IB) : index_bits;
        shifted  = s_address >> offset_bits;
        set_mask = (32'd1 << ib) - 32'd1;
        set_full = shifted & set_mask;
        sh_tot   = 5'(offset_bits) + 5'(ib);
        if (ways_in_use == '0) nways = (WAY_W+1)'(1);
        else if (ways_in_use > 4'(WAYS)) nways = (WAY_W+1)'(WAYS);
        else nways = (WAY_W+1)'(ways_in_use);
    end

    // Search, victim choice and new row
    line_t          ln [WAYS];
    line_t          nl [WAYS];
    logic           found, empty, wb;
    logic [WAY_W-1:0] way, hway, eway, vway;
    logic [RW-1:0]  old_rank;
    logic [ROW_W-1:0] new_row;

    always_comb begin
        found = 1'b0; empty = 1'b0; hway = '0; eway = '0; vway = '0;
        for (int i = 0; i < WAYS; i++) begin
            ln[i] = rd_row_reg[i*LINE_W +: LINE_W];
        end
        for (int i = WAYS - 1; i >= 0; i--) begin
            if ((WAY_W+1)'(i) < nways_reg) begin
                if (ln[i].valid && ln[i].tag == tag_reg) begin
                    found = 1'b1; hway = WAY_W'(i);
                end
                if (!ln[i].valid) begin
                    empty = 1'b1; eway = WAY_W'(i);
                end
            end
        end
        for (int i = 1; i < WAYS; i++) begin
            if ((WAY_W+1)'(i) < nways_reg && ln[i].rank > ln[vway].rank) vway = WAY_W'(i);
        end
        wb = 1'b0;
        if (found) begin
            way = hway; old_rank = ln[hway].rank;
        end else if (empty) begin
            way = eway; old_rank = lwct_pkg::RANK_TOP;
        end else begin
            way = vway; old_rank = ln[vway].rank; wb = ln[vway].dirty;
        end
        for (int i = 0; i < WAYS; i++) begin
            nl[i] = ln[i];
            if ((WAY_W+1)'(i) < nways_reg && WAY_W'(i) != way && ln[i].valid
                    && ln[i].rank < old_rank) begin
                nl[i].rank = ln[i].rank + RW'(1);
            end
        end
        nl[way].rank = '0;
        if (found) begin
            nl[way].dirty = ln[way].dirty | mode_reg;
        end else begin
            nl[way].valid = 1'b1;
            nl[way].dirty = mode_reg;
            nl[way].tag   = tag_reg;
        end
        for (int i = 0; i < WAYS; i++) begin
            new_row[i*LINE_W +: LINE_W] = nl[i];
        end
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.clear) mem[clr_ptr_reg] <= '0;
        else if (cmd.update) mem[set_reg] <= new_row;
        if (cmd.lookup) rd_row_reg <= mem[set_full[SET_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) clr_ptr_reg <= '0;
        else if (cmd.clear) clr_ptr_reg <= status.clear_done ? '0 : clr_ptr_reg + SET_W'(1);
    end
    assign status.clear_done = cmd.clear && (clr_ptr_reg == SET_W'(SETS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            set_reg   <= set_full[SET_W-1:0];
            tag_reg   <= s_address >> sh_tot;
            mode_reg  <= s_mode;
            nways_reg <= nways;
        end
        if (cmd.update) begin
            hit_reg <= found;
            wb_reg  <= wb;
            way_reg <= 3'(way);
        end
    end

    assign m_hit        = hit_reg;
    assign m_write_back = wb_reg;
    assign m_way_used   = way_reg;

    a_hit_no_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update && found |-> !wb) else $error("write-back on hit");
    a_way_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> (WAY_W+1)'(way) < nways_reg) else $error("way out of range");
    a_clr_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        status.clear_done |=> clr_ptr_reg == '0) else $error("clear pointer");

endmodule

### hdl/lru_writeback_cache_tags_top.sv
// Top level of the LRU write-back cache tag store.
// Holds the APB registers and joins lwct_ctrl and lwct_dp. Depends on lwct_pkg.
//
// Usage: s_valid/s_ready carry one access transaction (s_mode: 0 read,
// 1 write; s_address). m_valid/m_ready carry the result transaction
// (m_hit, m_write_back, m_way_used). Each access first reads the whole set
// row from the set memory, then compares all ways, chooses the victim,
// writes the updated row back and registers the result. One access is in
// flight at a time; no new access is taken until its update is done.
// After reset the block runs a clearing pass over all MAX_SETS set rows
// (one set row per cycle) with s_ready low; APB writes are taken throughout.
// When the receiver stalls, the result holds in its output register and
// s_ready stays low until it is taken (an access is accepted in the cycle
// the result leaves).
// Configuration (offset_bits @0x0, index_bits @0x4, ways_in_use @0x8) is to
// be written only while idle; the block itself does not enforce this.
// Lines survive a configuration change.
module lru_writeback_cache_tags_top #(
    parameter int MAX_SETS = lwct_pkg::MAX_SETS,
    parameter int MAX_WAYS = lwct_pkg::MAX_WAYS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic        m_write_back,
    output logic [2:0]  m_way_used
);

    logic [3:0] offset_reg, index_reg, ways_reg;
    logic       wr_en;
    lwct_pkg::cmd_t    cmd;
    lwct_pkg::status_t status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register write; unknown addresses drop the write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= lwct_pkg::OFFSET_RESET;
            index_reg  <= lwct_pkg::INDEX_RESET;
            ways_reg   <= lwct_pkg::WAYS_RESET;
        end else if (wr_en && paddr[1:0] == 2'b00) begin
            unique case (paddr[3:2])
                lwct_pkg::REG_OFFSET: offset_reg <= pwdata[3:0];
                lwct_pkg::REG_INDEX:  index_reg  <= pwdata[3:0];
                lwct_pkg::REG_WAYS:   ways_reg   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            lwct_pkg::REG_OFFSET: prdata = {28'd0, offset_reg};
            lwct_pkg::REG_INDEX:  prdata = {28'd0, index_reg};
            lwct_pkg::REG_WAYS:   prdata = {28'd0, ways_reg};
            default:              prdata = '0;
        endcase
    end

    lwct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    lwct_dp #(
        .SETS (MAX_SETS),
        .WAYS (MAX_WAYS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .offset_bits  (offset_reg),
        .index_bits   (index_reg),
        .ways_in_use  (ways_reg),
        .s_mode       (s_mode),
        .s_address    (s_address),
        .m_hit        (m_hit),
        .m_write_back (m_write_back),
        .m_way_used   (m_way_used)
    );

endmodule

### dv/lwct_checker.sv
// Checker for the LRU write-back cache tag store: watches both channels,
// keeps its own copy of tags, dirty bits and recency ranks, and compares.
// Depends on lwct_pkg.
module lwct_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_address,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_hit,
    input  logic        m_write_back,
    input  logic [2:0]  m_way_used,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic       hit;
        logic       write_back;
        logic [2:0] way;
    } lookup_t;

    localparam int LINES  = lwct_pkg::MAX_SETS * lwct_pkg::MAX_WAYS;
    localparam int MAX_IB = $clog2(lwct_pkg::MAX_SETS + 1) - 1;

    logic                        valid_q [LINES];
    logic                        dirty_q [LINES];
    logic [31:0]                 tag_q   [LINES];
    logic [lwct_pkg::RANK_W-1:0] rank_q  [LINES];
    logic [lwct_pkg::CFG_W-1:0]  offset_cfg, index_cfg, ways_cfg;
    lookup_t                     lookups_due[$];

    assign pending = lookups_due.size();

    function automatic void promote(int base, int nways, int way, int old_rank);
        for (int i = 0; i < nways; i++)
            if (i != way && valid_q[base+i] && int'(rank_q[base+i]) < old_rank)
                rank_q[base+i] = rank_q[base+i] + 1'b1;
        rank_q[base+way] = '0;
    endfunction

    function automatic lookup_t cache_access(logic is_write, logic [31:0] addr);
        int          ib, nways, set_no, base, way, old_rank;
        logic [31:0] tag;
        lookup_t     r;
        ib     = (int'(index_cfg) > MAX_IB) ? MAX_IB : int'(index_cfg);
        nways  = (ways_cfg == '0) ? 1 :
                 ((int'(ways_cfg) > lwct_pkg::MAX_WAYS) ? lwct_pkg::MAX_WAYS
                                                        : int'(ways_cfg));
        set_no = int'((64'(addr) >> offset_cfg) & ((64'd1 << ib) - 64'd1));
        tag    = 32'(64'(addr) >> (int'(offset_cfg) + ib));
        base   = set_no * lwct_pkg::MAX_WAYS;
        r      = '0;
        way    = -1;
        for (int i = 0; i < nways; i++)
            if (way < 0 && valid_q[base+i] && tag_q[base+i] == tag) way = i;
        if (way >= 0) begin
            r.hit = 1'b1;
            promote(base, nways, way, int'(rank_q[base+way]));
            if (is_write) dirty_q[base+way] = 1'b1;
        end else begin
            for (int i = 0; i < nways; i++)
                if (way < 0 && !valid_q[base+i]) way = i;
            if (way >= 0) begin
                old_rank = int'(lwct_pkg::RANK_TOP);
            end else begin
                way = 0;
                for (int i = 1; i < nways; i++)
                    if (rank_q[base+i] > rank_q[base+way]) way = i;
                old_rank     = int'(rank_q[base+way]);
                r.write_back = dirty_q[base+way];
            end
            valid_q[base+way] = 1'b1;
            tag_q[base+way]   = tag;
            dirty_q[base+way] = is_write;
            promote(base, nways, way, old_rank);
        end
        r.way = 3'(way);
        return r;
    endfunction

    always @(posedge aclk) begin
        lookup_t exp_r;
        if (!aresetn) begin
            for (int i = 0; i < LINES; i++) begin
                valid_q[i] = 1'b0;
                dirty_q[i] = 1'b0;
                tag_q[i]   = '0;
                rank_q[i]  = '0;
            end
            offset_cfg = lwct_pkg::OFFSET_RESET;
            index_cfg  = lwct_pkg::INDEX_RESET;
            ways_cfg   = lwct_pkg::WAYS_RESET;
            lookups_due.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (lookups_due.size() == 0) begin
                    $display("%0t: result with none expected: hit=%b wb=%b way=%0d",
                             $time, m_hit, m_write_back, m_way_used);
                    fail_count++;
                end else begin
                    exp_r = lookups_due.pop_front();
                    if (exp_r.hit !== m_hit || exp_r.write_back !== m_write_back
                        || exp_r.way !== m_way_used) begin
                        $display({"%0t: mismatch expected hit=%b wb=%b way=%0d,",
                                  " actual hit=%b wb=%b way=%0d"},
                                 $time, exp_r.hit, exp_r.write_back, exp_r.way,
                                 m_hit, m_write_back, m_way_used);
                        fail_count++;
                    end
                end
            end
            // Predict with the configuration in force before this edge.
            if (s_valid && s_ready)
                lookups_due.push_back(cache_access(s_mode, s_address));
            if (psel && penable && pwrite && pready) begin
                unique case (paddr[3:2])
                    lwct_pkg::REG_OFFSET: offset_cfg = pwdata[3:0];
                    lwct_pkg::REG_INDEX:  index_cfg  = pwdata[3:0];
                    lwct_pkg::REG_WAYS:   ways_cfg   = pwdata[3:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

### dv/tb.sv
// Testbench top for the LRU write-back cache tag store: drives accesses and
// APB writes, and gives the verdict. Depends on lwct_pkg and lwct_checker.
module tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0, s_ready, s_mode = 1'b0;
    logic [31:0] s_address = '0;
    logic        m_valid, m_ready = 1'b0;
    logic        m_hit, m_write_back;
    logic [2:0]  m_way_used;
    int          fail_count, pending;
    int          cycle_count = 0;
    bit          rx_quiet = 1'b0;   // no random stalls on the receiver
    bit          rx_hold  = 1'b0;   // long receiver hold-off request
    bit          tx_quiet = 1'b0;
    logic [31:0] recent_addr[$];

    localparam int CYCLE_LIMIT = 400000;

    lru_writeback_cache_tags_top i_dut (.*);

    lwct_checker i_checker (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog: the clearing pass plus ~1600 accesses fit well inside.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lru_writeback_cache_tags_top verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here.
    initial begin
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold && !hold_used) begin
                hold_left = 200;
                hold_used = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= rx_quiet ? 1'b1 : ($urandom_range(99) >= 9);
            end
        end
    end

    task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Maybe idle first, then offer one access and hold it until accepted.
    task automatic send_access(input logic is_write, input logic [31:0] addr);
        @(negedge aclk);
        while (!tx_quiet && $urandom_range(99) < 9) @(negedge aclk);
        s_valid   <= 1'b1;
        s_mode    <= is_write;
        s_address <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid <= 1'b0;
        recent_addr.push_back(addr);
        if (recent_addr.size() > 24) void'(recent_addr.pop_front());
    endtask

    // Drain the result queue, then give the block a few spare cycles.
    task automatic wait_drained();
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Reuse addresses, or poke neighbors of a few hot sets so sets fill and evict.
    function automatic logic [31:0] pick_address();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40 && recent_addr.size() > 0)
            return recent_addr[$urandom_range(recent_addr.size() - 1)];
        if (sel < 85)
            return {4'($urandom_range(15)), 16'h0, 4'($urandom_range(15)),
                    8'($urandom_range(255))} ^ (32'($urandom_range(3)) << 12);
        return $urandom;
    endfunction

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++)
            send_access(1'($urandom_range(1)), pick_address());
    endtask

    initial begin
        logic [3:0] offs, idx, ways;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: default split, fill a set past its ways, dirty evictions.
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        send_access(1'b0, 32'h0000_0000);
        send_access(1'b1, 32'hFFFF_FFFF);
        send_access(1'b1, 32'hFFFF_FFFF);
        for (int w = 0; w < 10; w++)
            send_access(w[0], 32'(w) << 7);
        send_access(1'b0, 32'h0000_0000);
        send_access(1'b1, 32'h0000_0080);
        wait_drained();

        // Extremes: oversize index, zero and oversize ways, zero offset and offset 12.
        apb_write(lwct_pkg::REG_OFFSET, 32'd0);
        apb_write(lwct_pkg::REG_INDEX, 32'd15);
        apb_write(lwct_pkg::REG_WAYS, 32'd0);
        send_access(1'b1, 32'h1234_5678);
        send_access(1'b0, 32'h1234_5678);
        send_access(1'b0, 32'h5555_AAAA);
        send_access(1'b1, 32'hAAAA_5555);
        wait_drained();
        apb_write(lwct_pkg::REG_OFFSET, 32'd12);
        apb_write(lwct_pkg::REG_INDEX, 32'd0);
        apb_write(lwct_pkg::REG_WAYS, 32'd15);
        for (int w = 0; w < 10; w++)
            send_access(1'b1, 32'(w) << 12);
        wait_drained();

        // Long hold-off with the sender still offering, then random phases.
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        apb_write(lwct_pkg::REG_OFFSET, 32'd3);
        apb_write(lwct_pkg::REG_INDEX, 32'd4);
        apb_write(lwct_pkg::REG_WAYS, 32'd8);
        rx_hold = 1'b1;
        random_phase(200);
        wait_drained();

        // Shrink ways with lines still present so rank ties appear.
        apb_write(lwct_pkg::REG_WAYS, 32'd3);
        random_phase(150);
        wait_drained();

        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        random_phase(250);
        wait_drained();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        for (int ph = 0; ph < 6; ph++) begin
            offs = 4'($urandom_range(12));
            idx  = 4'($urandom_range(9));
            ways = 4'($urandom_range(1, 8));
            apb_write(lwct_pkg::REG_OFFSET, {28'h0, offs});
            apb_write(lwct_pkg::REG_INDEX, {28'h0, idx});
            apb_write(lwct_pkg::REG_WAYS, {28'h0, ways});
            random_phase(160);
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("lru_writeback_cache_tags_top verification clean");
        end else begin
            $display("lru_writeback_cache_tags_top verification failed");
        end
        $finish;
    end
endmodule
